// ===== hdl/dalmr_pkg.sv =====
// Shared types and constants for the axis/diagonal line rasterizer with max blending.
// Used by the walker, the address unit, the top level and the bench; depends on nothing.
package dalmr_pkg;

    // Default store geometry and pixel precision
    localparam int MAX_WIDTH_DEF      = 256;
    localparam int MAX_HEIGHT_DEF     = 256;
    localparam int INTENSITY_BITS_DEF = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 8;
    localparam int INT_W    = 16;
    localparam int RADDR_W  = 16;
    localparam int WIDTH_W  = 9;
    localparam int ROW_W    = 10;   // signed row, covers -512 .. 511
    localparam int CNT_W    = 9;    // pixels left in a segment, up to 256
    localparam int PROD_W   = 20;   // signed row * image_width
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Input request packing, lowest bit first
    localparam int OFS_FUNC  = 0;
    localparam int OFS_XB    = OFS_FUNC + FUNC_W;
    localparam int OFS_YB    = OFS_XB + COORD_W;
    localparam int OFS_XE    = OFS_YB + COORD_W;
    localparam int OFS_YE    = OFS_XE + COORD_W;
    localparam int OFS_INT   = OFS_YE + COORD_W;
    localparam int OFS_RADDR = OFS_INT + INT_W;

    // Register map: index is paddr[REG_IDX_BIT]
    localparam int   REG_IDX_BIT     = 2;
    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd256;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DRAW,
        ST_READ
    } state_t;

    // One pixel coordinate from the segment walker
    typedef struct packed {
        logic                      valid;
        logic [COORD_W-1:0]        x;
        logic signed [ROW_W-1:0]   row;
    } pix_t;

endpackage

// ===== hdl/dalmr_store.sv =====
// Pixel store: one write port, one read port with registered read data.
// Depends on nothing; sized by the top level.
module dalmr_store #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; hold data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dalmr_walk.sv =====
// Segment walker: orders endpoints, classifies the segment, emits one pixel per cycle.
// Depends on dalmr_pkg.
module dalmr_walk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dalmr_pkg::COORD_W-1:0] x_begin,
    input  logic [dalmr_pkg::COORD_W-1:0] y_begin,
    input  logic [dalmr_pkg::COORD_W-1:0] x_end,
    input  logic [dalmr_pkg::COORD_W-1:0] y_end,
    output dalmr_pkg::pix_t               pix,
    output logic                          busy
);

    logic [dalmr_pkg::COORD_W-1:0]      bx, by, ex, ey, lo, hi, span;
    logic                               swap, horiz, vert, rising;
    logic [dalmr_pkg::COORD_W-1:0]      x_reg, x_next, x_init;
    logic signed [dalmr_pkg::ROW_W-1:0] row_reg, row_next, row_init;
    logic [dalmr_pkg::CNT_W-1:0]        cnt_reg, cnt_next, cnt_init;
    logic                               dx_reg, dx_next, dx_init;
    logic                               up_reg, up_next, up_init;
    logic                               dn_reg, dn_next, dn_init;

    // Order by column and classify
    always_comb begin
        swap   = x_end < x_begin;
        bx     = swap ? x_end   : x_begin;
        by     = swap ? y_end   : y_begin;
        ex     = swap ? x_begin : x_end;
        ey     = swap ? y_begin : y_end;
        horiz  = by == ey;
        vert   = (bx == ex) && !horiz;
        rising = by < ey;
        lo     = rising ? by : ey;
        hi     = rising ? ey : by;
        span   = ex - bx;

        x_init = bx;
        if (horiz) begin
            row_init = $signed({2'b00, ey});
            dx_init  = 1'b1;
            up_init  = 1'b0;
            dn_init  = 1'b0;
            cnt_init = {1'b0, span};
        end else if (vert) begin
            row_init = $signed({2'b00, lo});
            dx_init  = 1'b0;
            up_init  = 1'b1;
            dn_init  = 1'b0;
            cnt_init = {1'b0, hi - lo};
        end else begin
            row_init = $signed({2'b00, by});
            dx_init  = 1'b1;
            up_init  = rising;
            dn_init  = !rising;
            cnt_init = {1'b0, span} + 9'd1;
        end
    end

    // Load on start, advance one pixel while pixels remain
    always_comb begin
        x_next   = x_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        dx_next  = dx_reg;
        up_next  = up_reg;
        dn_next  = dn_reg;
        if (start) begin
            x_next   = x_init;
            row_next = row_init;
            cnt_next = cnt_init;
            dx_next  = dx_init;
            up_next  = up_init;
            dn_next  = dn_init;
        end else if (cnt_reg != '0) begin
            x_next   = x_reg + {{(dalmr_pkg::COORD_W-1){1'b0}}, dx_reg};
            if (up_reg) begin
                row_next = row_reg + 10'sd1;
            end else if (dn_reg) begin
                row_next = row_reg - 10'sd1;
            end
            cnt_next = cnt_reg - 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        row_reg <= row_next;
        dx_reg  <= dx_next;
        up_reg  <= up_next;
        dn_reg  <= dn_next;
    end

    assign pix.valid = cnt_reg != '0;
    assign pix.x     = x_reg;
    assign pix.row   = row_reg;
    assign busy      = cnt_reg != '0;

endmodule

// ===== hdl/dalmr_addr.sv =====
// Address unit: row * image_width in one stage, then add column and range check.
// Depends on dalmr_pkg.
module dalmr_addr #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dalmr_pkg::pix_t               pix,
    input  logic [dalmr_pkg::WIDTH_W-1:0] image_width,
    output logic                          issue_valid,
    output logic [ADDR_W-1:0]             issue_addr,
    output logic                          busy
);

    localparam int CALC_W = (ADDR_W + 2 > dalmr_pkg::PROD_W + 1) ?
                            ADDR_W + 2 : dalmr_pkg::PROD_W + 1;

    logic                                s1_valid_reg;
    logic [dalmr_pkg::COORD_W-1:0]       s1_x_reg;
    logic signed [dalmr_pkg::PROD_W-1:0] s1_prod_reg, s1_prod_next;
    logic signed [CALC_W-1:0]            sum;
    logic                                in_range;

    // Multiply stage
    assign s1_prod_next = dalmr_pkg::PROD_W'(pix.row)
                        * dalmr_pkg::PROD_W'($signed({1'b0, image_width}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge aclk) begin
        s1_x_reg    <= pix.x;
        s1_prod_reg <= s1_prod_next;
    end

    // Add column, drop addresses outside the store
    always_comb begin
        sum      = $signed({{(CALC_W-dalmr_pkg::COORD_W){1'b0}}, s1_x_reg})
                 + CALC_W'(s1_prod_reg);
        in_range = !sum[CALC_W-1] && (sum < $signed(CALC_W'(DEPTH)));
    end

    assign issue_valid = s1_valid_reg && in_range;
    assign issue_addr  = sum[ADDR_W-1:0];
    assign busy        = s1_valid_reg;

endmodule

// ===== hdl/diagonal_axis_line_max_raster.sv =====
// Top level of the line rasterizer: stream ports, register port, command sequencer.
// Depends on dalmr_pkg, dalmr_store, dalmr_walk and dalmr_addr.

// Keeps a store of MAX_WIDTH*MAX_HEIGHT unsigned Q0.16 pixels in one synchronous
// memory and takes one request at a time. A draw walks its segment one pixel per
// cycle through walker, multiply stage, memory read and compare-write. A clear
// writes zero to every entry, one per cycle (MAX_WIDTH*MAX_HEIGHT entries, 65536 at
// the defaults). The same sweep runs after reset, during which no request is taken;
// register writes are accepted at any time. A read passes through the memory's read
// register to the output register, which holds the result while the next request
// is taken. Within a draw, back-to-back accesses to one entry need no forwarding
// since every pixel of a segment carries the same intensity; requests follow each
// other only after the previous one has fully retired, which interlocks the memory.
module diagonal_axis_line_max_raster #(
    parameter int MAX_WIDTH      = dalmr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = dalmr_pkg::MAX_HEIGHT_DEF,
    parameter int INTENSITY_BITS = dalmr_pkg::INTENSITY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // func, x_begin, y_begin, x_end, y_end, intensity, read_address, zero pad
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dalmr_pkg::S_DATA_W-1:0] s_tdata,
    // pixel_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dalmr_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dalmr_pkg::PADDR_W-1:0]  paddr,
    input  logic [dalmr_pkg::PDATA_W-1:0]  pwdata,
    output logic [dalmr_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PIX_W  = (INTENSITY_BITS < dalmr_pkg::INT_W) ?
                            INTENSITY_BITS : dalmr_pkg::INT_W;
    localparam int RD_W   = (ADDR_W > dalmr_pkg::RADDR_W) ?
                            ADDR_W + 1 : dalmr_pkg::RADDR_W + 1;

    // Request fields
    logic [dalmr_pkg::FUNC_W-1:0]  in_func;
    logic [dalmr_pkg::COORD_W-1:0] in_xb, in_yb, in_xe, in_ye;
    logic [dalmr_pkg::INT_W-1:0]   in_int;
    logic [dalmr_pkg::RADDR_W-1:0] in_raddr;
    logic [RD_W-1:0]               rd_ext;
    logic                          rd_ok;
    logic                          accept;
    logic                          start_draw;

    assign in_func  = s_tdata[dalmr_pkg::OFS_FUNC +: dalmr_pkg::FUNC_W];
    assign in_xb    = s_tdata[dalmr_pkg::OFS_XB +: dalmr_pkg::COORD_W];
    assign in_yb    = s_tdata[dalmr_pkg::OFS_YB +: dalmr_pkg::COORD_W];
    assign in_xe    = s_tdata[dalmr_pkg::OFS_XE +: dalmr_pkg::COORD_W];
    assign in_ye    = s_tdata[dalmr_pkg::OFS_YE +: dalmr_pkg::COORD_W];
    assign in_int   = s_tdata[dalmr_pkg::OFS_INT +: dalmr_pkg::INT_W];
    assign in_raddr = s_tdata[dalmr_pkg::OFS_RADDR +: dalmr_pkg::RADDR_W];
    assign rd_ext   = RD_W'(in_raddr);
    assign rd_ok    = rd_ext < RD_W'(DEPTH);

    dalmr_pkg::state_t state_reg, state_next;

    assign s_tready   = state_reg == dalmr_pkg::ST_IDLE;
    assign accept     = s_tvalid && s_tready;
    assign start_draw = accept && (in_func == dalmr_pkg::FUNC_DRAW);

    // Configuration register
    logic [dalmr_pkg::WIDTH_W-1:0] width_reg;
    logic                          cfg_sel;

    assign cfg_sel = paddr[dalmr_pkg::REG_IDX_BIT] == dalmr_pkg::REG_IMAGE_WIDTH;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? dalmr_pkg::PDATA_W'(width_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= dalmr_pkg::WIDTH_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            width_reg <= pwdata[dalmr_pkg::WIDTH_W-1:0];
        end
    end

    // Walker and address unit
    dalmr_pkg::pix_t   pix;
    logic              walk_busy;
    logic              s1_busy;
    logic              issue_valid;
    logic [ADDR_W-1:0] issue_addr;

    dalmr_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_draw),
        .x_begin (in_xb),
        .y_begin (in_yb),
        .x_end   (in_xe),
        .y_end   (in_ye),
        .pix     (pix),
        .busy    (walk_busy)
    );

    dalmr_addr #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix         (pix),
        .image_width (width_reg),
        .issue_valid (issue_valid),
        .issue_addr  (issue_addr),
        .busy        (s1_busy)
    );

    // Pixel store
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [PIX_W-1:0]  mem_wdata, mem_rdata;

    dalmr_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer state
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic [PIX_W-1:0]  value_reg, value_next;
    logic              rd_oob_reg, rd_oob_next;
    logic              p2_valid_reg, p2_valid_next;
    logic [ADDR_W-1:0] p2_addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [dalmr_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_load;
    logic              draw_done;

    assign draw_done = !walk_busy && !s1_busy && !p2_valid_reg;

    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        value_next     = value_reg;
        rd_oob_next    = rd_oob_reg;
        mem_we         = 1'b0;
        mem_waddr      = p2_addr_reg;
        mem_wdata      = value_reg;
        mem_re         = 1'b0;
        mem_raddr      = issue_addr;
        out_load       = 1'b0;
        p2_valid_next  = 1'b0;
        unique case (state_reg)
            dalmr_pkg::ST_SWEEP: begin
                // Zero one entry a cycle
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                mem_wdata  = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = dalmr_pkg::ST_IDLE;
                end
            end
            dalmr_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (dalmr_pkg::func_t'(in_func))
                        dalmr_pkg::FUNC_CLEAR: begin
                            sweep_next = '0;
                            state_next = dalmr_pkg::ST_SWEEP;
                        end
                        dalmr_pkg::FUNC_DRAW: begin
                            value_next = in_int[PIX_W-1:0];
                            state_next = dalmr_pkg::ST_DRAW;
                        end
                        dalmr_pkg::FUNC_READ: begin
                            mem_re      = 1'b1;
                            mem_raddr   = rd_ext[ADDR_W-1:0];
                            rd_oob_next = !rd_ok;
                            state_next  = dalmr_pkg::ST_READ;
                        end
                        default: begin
                            state_next = dalmr_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dalmr_pkg::ST_DRAW: begin
                // Read issued pixel, write back where the new value is larger
                mem_re        = issue_valid;
                mem_raddr     = issue_addr;
                p2_valid_next = issue_valid;
                mem_we        = p2_valid_reg && (value_reg > mem_rdata);
                if (draw_done) begin
                    state_next = dalmr_pkg::ST_IDLE;
                end
            end
            dalmr_pkg::ST_READ: begin
                // Hold the read data until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = dalmr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dalmr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = rd_oob_reg ? '0 : dalmr_pkg::M_DATA_W'(mem_rdata);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dalmr_pkg::ST_SWEEP;
            sweep_reg     <= '0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            p2_valid_reg  <= p2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        rd_oob_reg   <= rd_oob_next;
        p2_addr_reg  <= issue_addr;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A new request is taken only with the draw pipeline empty
    a_ready_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!walk_busy && !s1_busy && !p2_valid_reg))
        else $error("request accepted with draw pipeline busy");

    // The walker runs only inside a draw
    a_walk_in_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_busy |-> (state_reg == dalmr_pkg::ST_DRAW))
        else $error("walker active outside draw");

    // A read request moves to the read-data state next cycle
    a_read_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (in_func == dalmr_pkg::FUNC_READ)) |=>
        (state_reg == dalmr_pkg::ST_READ))
        else $error("read request not followed by read-data state");
`endif

endmodule

// ===== sim/diagonal_axis_line_max_raster_tb.sv =====
// Self-checking bench for the line rasterizer: mirrors the pixel store, predicts every
// pixel read and compares it against the result stream. Depends on dalmr_pkg and the RTL.
module diagonal_axis_line_max_raster_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dalmr_pkg::*;

    localparam int STORE_DEPTH   = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 300;      // longest segment plus pipeline
    localparam int LONG_HOLD     = 3000;
    localparam logic [PADDR_W-1:0] ADDR_IMAGE_WIDTH =
        PADDR_W'(int'(REG_IMAGE_WIDTH) * 4);

    typedef struct {
        func_t       func;
        logic [7:0]  xb;
        logic [7:0]  yb;
        logic [7:0]  xe;
        logic [7:0]  ye;
        logic [15:0] inten;
        logic [15:0] raddr;
    } raster_req_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // func, x_begin, y_begin, x_end, y_end, intensity,
                                          // read_address, zero pad
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // pixel_value
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Mirror of the block state
    logic [15:0]        pixel_mirror [STORE_DEPTH];
    logic [WIDTH_W-1:0] mirror_width = WIDTH_RESET;

    raster_req_t raster_reqs[$];
    logic [15:0] expected_pixels[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_wanted    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int gen_width      = 256;
    int clears_left    = 3;
    int n_draw, n_read, n_clear, n_noise, n_widths, reads_checked;

    diagonal_axis_line_max_raster i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic [S_DATA_W-1:0] pack_req(raster_req_t r);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[OFS_FUNC +: FUNC_W]   = r.func;
        d[OFS_XB +: COORD_W]    = r.xb;
        d[OFS_YB +: COORD_W]    = r.yb;
        d[OFS_XE +: COORD_W]    = r.xe;
        d[OFS_YE +: COORD_W]    = r.ye;
        d[OFS_INT +: INT_W]     = r.inten;
        d[OFS_RADDR +: RADDR_W] = r.raddr;
        return d;
    endfunction

    // Max-blend one pixel; drop it when the address leaves the store
    function automatic void blend_pixel(int x, int row, logic [15:0] v);
        int a;
        a = x + row * int'(mirror_width);
        if (a < 0 || a >= STORE_DEPTH)
            return;
        if (v > pixel_mirror[a])
            pixel_mirror[a] = v;
    endfunction

    function automatic void rasterize_segment(raster_req_t r);
        int bx, by, ex, ey, t, k, lo, hi, step;
        bx = r.xb;
        by = r.yb;
        ex = r.xe;
        ey = r.ye;
        if (ex < bx) begin
            t = bx; bx = ex; ex = t;
            t = by; by = ey; ey = t;
        end
        if (by == ey) begin
            for (k = bx; k < ex; k++)
                blend_pixel(k, ey, r.inten);
        end else if (bx == ex) begin
            lo = (by < ey) ? by : ey;
            hi = (by < ey) ? ey : by;
            for (k = lo; k < hi; k++)
                blend_pixel(bx, k, r.inten);
        end else begin
            step = (by < ey) ? 1 : -1;
            for (k = 0; k <= ex - bx; k++)
                blend_pixel(bx + k, by + k * step, r.inten);
        end
    endfunction

    // Update the mirror for one accepted request and queue the pixel a read returns
    function automatic void apply_request(raster_req_t r);
        case (r.func)
            FUNC_CLEAR: begin
                foreach (pixel_mirror[i])
                    pixel_mirror[i] = '0;
                n_clear++;
            end
            FUNC_DRAW: begin
                rasterize_segment(r);
                n_draw++;
            end
            FUNC_READ: begin
                expected_pixels = {expected_pixels, pixel_mirror[r.raddr]};
                n_read++;
            end
            default: n_noise++;
        endcase
    endfunction

    // Request driver: hold a request until taken, else idle at the phase rate
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(raster_reqs[0]);
                void'(raster_reqs.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (raster_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pack_req(raster_reqs[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_wanted) begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end
    end

    // Result monitor: check each pixel against the oldest pending read
    always @(posedge aclk) begin : result_monitor
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel result with no read pending", 32'(m_tdata), '0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[15:0] !== want)
                    report_mismatch("pixel_value", 32'(m_tdata), 32'(want));
                reads_checked++;
            end
        end
        m_tready <= (hold_left == 0) && (hold_served == hold_wanted) &&
                    ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Run timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Write image_width over the register port, then read it back
    task automatic write_width(int w);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IMAGE_WIDTH;
        pwdata  <= PDATA_W'(w);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== PDATA_W'(w & 'h1FF))
            report_mismatch("image_width readback", prdata, PDATA_W'(w & 'h1FF));
        psel    <= 1'b0;
        penable <= 1'b0;
        mirror_width = WIDTH_W'(w);
        gen_width    = w & 'h1FF;
        n_widths++;
    endtask

    task automatic push_req(func_t f, int xb, int yb, int xe, int ye, int inten, int raddr);
        raster_req_t r;
        r.func  = f;
        r.xb    = xb[7:0];
        r.yb    = yb[7:0];
        r.xe    = xe[7:0];
        r.ye    = ye[7:0];
        r.inten = inten[15:0];
        r.raddr = raddr[15:0];
        raster_reqs = {raster_reqs, r};
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    function automatic int pix_addr(int x, int y);
        return (x + y * gen_width) & 'hFFFF;
    endfunction

    function automatic int rand_inten();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 'hFFFF;
            default: return $urandom_range(0, 'hFFFF);
        endcase
    endfunction

    // Mostly local draw-then-read groups; the rest long draws, stray reads, noise, clears
    task automatic queue_random_mix(int n);
        int cnt, roll, cx, cy, nd, len, sx, sy, xe, ye, k, j, pick;
        int hx[3];
        int hy[3];
        cnt = 0;
        while (cnt < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                cx = $urandom_range(0, 255);
                cy = $urandom_range(0, 255);
                nd = $urandom_range(1, 3);
                for (j = 0; j < nd; j++) begin
                    len = $urandom_range(0, 12);
                    sx  = $urandom_range(0, 1) ? 1 : -1;
                    sy  = $urandom_range(0, 1) ? 1 : -1;
                    k   = $urandom_range(0, len);
                    case ($urandom_range(0, 3))
                        0: begin
                            xe = clamp_coord(cx + sx * len); ye = cy;
                            hx[j] = clamp_coord(cx + sx * k); hy[j] = cy;
                        end
                        1: begin
                            xe = cx; ye = clamp_coord(cy + sy * len);
                            hx[j] = cx; hy[j] = clamp_coord(cy + sy * k);
                        end
                        2: begin
                            xe = clamp_coord(cx + sx * len); ye = clamp_coord(cy + sy * len);
                            hx[j] = clamp_coord(cx + sx * k); hy[j] = clamp_coord(cy + sy * k);
                        end
                        default: begin
                            xe = clamp_coord(cx + sx * len); ye = $urandom_range(0, 255);
                            hx[j] = cx; hy[j] = cy;
                        end
                    endcase
                    if ($urandom_range(0, 1))
                        push_req(FUNC_DRAW, cx, cy, xe, ye, rand_inten(), $urandom());
                    else
                        push_req(FUNC_DRAW, xe, ye, cx, cy, rand_inten(), $urandom());
                    cnt++;
                end
                repeat ($urandom_range(1, 3)) begin
                    pick = $urandom_range(0, nd - 1);
                    push_req(FUNC_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(),
                             pix_addr(clamp_coord(hx[pick] + $urandom_range(0, 2) - 1),
                                      hy[pick]));
                    cnt++;
                end
            end else if (roll < 84) begin
                push_req(FUNC_DRAW, $urandom(), $urandom(), $urandom(), $urandom(),
                         rand_inten(), $urandom());
                cnt++;
            end else if (roll < 94) begin
                push_req(FUNC_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
                cnt++;
            end else if (roll < 98 || clears_left == 0) begin
                push_req(FUNC_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
            end else begin
                push_req(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
                clears_left--;
                cnt++;
            end
        end
    endtask

    // Wait for every request and result, then let a trailing draw retire
    task automatic wait_drain();
        while (raster_reqs.size() != 0 || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One random phase; a closing read returns only once everything before it retired
    task automatic run_phase(int w, int sidle, int rstall, int n);
        write_width(w);
        @(posedge aclk);
        send_idle_pct  <= sidle;
        recv_stall_pct <= rstall;
        @(negedge aclk);
        queue_random_mix(n);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, $urandom());
        wait_drain();
    endtask

    initial begin : stimulus
        int x, y;
        foreach (pixel_mirror[i])
            pixel_mirror[i] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: shapes, endpoint rules, blend rule, store edges, noise, clear
        @(negedge aclk);
        push_req(FUNC_DRAW, 10, 5, 14, 5, 'h8000, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(10, 5));
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(14, 5));
        push_req(FUNC_DRAW, 20, 7, 16, 7, 'h1234, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(16, 7));
        push_req(FUNC_DRAW, 3, 3, 3, 3, 'hFFFF, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(3, 3));
        push_req(FUNC_DRAW, 40, 10, 40, 4, 'h4444, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(40, 4));
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(40, 10));
        push_req(FUNC_DRAW, 0, 0, 255, 255, 'hFFFF, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, 'hFFFF);
        push_req(FUNC_DRAW, 255, 0, 0, 255, 'h0001, 'hFFFF);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(0, 255));
        push_req(FUNC_DRAW, 10, 5, 14, 5, 'h7FFF, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(10, 5));
        push_req(FUNC_DRAW, 100, 10, 104, 200, 'h00FF, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(104, 14));
        push_req(FUNC_DRAW, 250, 3, 255, 0, 'hABCD, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(253, 0));
        push_req(FUNC_DRAW, 0, 250, 255, 251, 'h5555, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(5, 255));
        push_req(FUNC_NONE, 'hFF, 'hFF, 'hFF, 'hFF, 'hFFFF, 'hFFFF);
        push_req(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
        push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(0, 0));
        wait_drain();

        // Random phases over width settings and idle patterns
        run_phase(1, 0, 0, 90);
        run_phase(511, 52, 0, 90);
        run_phase(0, 0, 52, 90);
        run_phase($urandom_range(2, 255), 8, 8, 90);

        // Back-pressure: park the output for a long stretch while requests keep coming
        write_width(256);
        @(posedge aclk);
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        hold_wanted    <= hold_wanted + 1;
        @(negedge aclk);
        repeat (20) begin
            x = $urandom_range(0, 250);
            y = $urandom_range(0, 255);
            push_req(FUNC_DRAW, x, y, x + 4, y, rand_inten(), 0);
            push_req(FUNC_READ, 0, 0, 0, 0, 0, pix_addr(x + $urandom_range(0, 4), y));
        end
        wait_drain();

        run_phase($urandom_range(1, 511), 8, 8, 90);

        $display("Covered %0d draws, %0d reads, %0d clears, %0d unused commands",
                 n_draw, n_read, n_clear, n_noise);
        $display("over %0d image_width settings; %0d pixel results checked",
                 n_widths, reads_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dalmr_pkg.sv
hdl/dalmr_store.sv
hdl/dalmr_walk.sv
hdl/dalmr_addr.sv
hdl/diagonal_axis_line_max_raster.sv
sim/diagonal_axis_line_max_raster_tb.sv
